// ===== design/fits_pkg.sv =====
// shared constants, types and controller/datapath interface for flat_index_to_subscripts
package fits_pkg;

    localparam int MAX_DIMS    = 6;
    localparam int DIM_WIDTH   = 16;
    localparam int INDEX_WIDTH = 48;
    localparam int DNUM_W      = 3;
    localparam int NUM_DIMS_W  = 3;
    localparam int STEP_W      = $clog2(INDEX_WIDTH);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = DIM_WIDTH;
    localparam int TUSER_W     = DNUM_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;

    typedef logic [MAX_DIMS-1:0][DIM_WIDTH-1:0] sizes_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              load;
        logic              div_step;
        logic              div_last;
        logic              out_load;
        logic [DNUM_W-1:0] dim;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== design/fits_ctrl.sv =====
// controller: sequences the per-dimension divisions and the output words
module fits_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fits_pkg::DNUM_W-1:0] n_last,
    input  fits_pkg::status_t           st,
    output fits_pkg::cmd_t              cmd
);

    fits_pkg::state_t                state_reg, state_next;
    logic [fits_pkg::DNUM_W-1:0]     dim_reg, dim_next;
    logic [fits_pkg::STEP_W-1:0]     step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fits_pkg::ST_IDLE;
            dim_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            dim_reg   <= dim_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dim_next   = dim_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.dim    = dim_reg;
        unique case (state_reg)
            fits_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    dim_next   = n_last;
                    step_next  = '0;
                    state_next = fits_pkg::ST_DIVIDE;
                end
            end
            fits_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (step_reg == fits_pkg::STEP_W'(fits_pkg::INDEX_WIDTH - 1)) begin
                    cmd.div_last = 1'b1;
                    step_next    = '0;
                    if (dim_reg == '0) begin
                        state_next = fits_pkg::ST_EMIT;
                    end else begin
                        dim_next = dim_reg - 1'b1;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            fits_pkg::ST_EMIT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    if (dim_reg == n_last) begin
                        state_next = fits_pkg::ST_IDLE;
                    end else begin
                        dim_next = dim_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = fits_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/fits_datapath.sv =====
// datapath: radix-2 divider, coordinate lanes and output register
module fits_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fits_pkg::cmd_t                   cmd,
    output fits_pkg::status_t                st,
    input  logic [fits_pkg::INDEX_WIDTH-1:0] flat_index,
    input  logic [fits_pkg::DNUM_W-1:0]      n_last,
    input  fits_pkg::sizes_t                 dim_size,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fits_pkg::DIM_WIDTH-1:0]   m_tdata,
    output logic [fits_pkg::TUSER_W-1:0]     m_tuser,
    output logic                             m_tlast
);

    logic [fits_pkg::INDEX_WIDTH-1:0] quo_reg;
    logic [fits_pkg::DIM_WIDTH-1:0]   rem_reg;
    logic [fits_pkg::DIM_WIDTH-1:0]   coord_reg [fits_pkg::MAX_DIMS];
    logic                             neg_reg;
    logic                             zero_reg;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [fits_pkg::DIM_WIDTH-1:0]   m_tdata_reg;
    logic [fits_pkg::TUSER_W-1:0]     m_tuser_reg;
    logic                             m_tlast_reg;

    logic [fits_pkg::DIM_WIDTH-1:0]   divisor;
    logic [fits_pkg::DIM_WIDTH:0]     trial;
    logic [fits_pkg::DIM_WIDTH:0]     diff;
    logic                             ge;
    logic [fits_pkg::DIM_WIDTH-1:0]   rem_step;
    logic                             zero_any;
    logic                             bad;

    always_comb begin
        zero_any = 1'b0;
        for (int k = 0; k < fits_pkg::MAX_DIMS; k++) begin
            if ((fits_pkg::DNUM_W'(k) <= n_last) && (dim_size[k] == '0)) begin
                zero_any = 1'b1;
            end
        end
    end

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign divisor  = dim_size[cmd.dim];
    assign trial    = {rem_reg, quo_reg[fits_pkg::INDEX_WIDTH-1]};
    assign diff     = trial - {1'b0, divisor};
    assign ge       = (trial >= {1'b0, divisor});
    assign rem_step = ge ? diff[fits_pkg::DIM_WIDTH-1:0] : trial[fits_pkg::DIM_WIDTH-1:0];

    // leftover quotient after the outermost dimension means index beyond total
    assign bad = neg_reg | zero_reg | (quo_reg != '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            quo_reg  <= flat_index;
            rem_reg  <= '0;
            neg_reg  <= flat_index[fits_pkg::INDEX_WIDTH-1];
            zero_reg <= zero_any;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[fits_pkg::INDEX_WIDTH-2:0], ge};
            rem_reg <= cmd.div_last ? '0 : rem_step;
            if (cmd.div_last) begin
                coord_reg[cmd.dim] <= rem_step;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= bad ? '0 : coord_reg[cmd.dim];
            m_tuser_reg <= {bad, cmd.dim};
            m_tlast_reg <= (cmd.dim == n_last);
        end
    end

    assign st.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign m_tuser     = m_tuser_reg;
    assign m_tlast     = m_tlast_reg;

endmodule

// ===== design/flat_index_to_subscripts.sv =====
// top level: row-major flat index to per-dimension subscripts
//
// Configuration: cfg_wr_en/cfg_index/cfg_data write num_dims (index 0) and
// the dimension sizes (index 1 = outermost, then inward up to index 6). Write
// only while no item is in flight; the block does not enforce this. Other indexes are ignored.
// Input: one signed 48-bit flat index per word on s_tdata.
// Output: one word per dimension in use, outermost first; m_tdata is the
// coordinate, m_tuser gives dimension number and invalid flag, m_tlast marks
// the innermost dimension. An invalid index (negative, a zero size, or not
// below the product of the sizes) gives the same run with coordinate 0.
// Sequence: a single radix-2 divider works through the dimensions innermost
// first, so an item goes through an accept step, the division of each
// dimension in turn, and then its output words. The next index is taken once
// the last word sits in the output register.
// Reset: num_dims and all sizes return to 1, no words pending.
// A stall on m_tready holds the current word and pauses emission.
module flat_index_to_subscripts (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fits_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fits_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fits_pkg::INDEX_WIDTH-1:0]    s_tdata,  // flat_index
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fits_pkg::DIM_WIDTH-1:0]      m_tdata,  // coordinate
    output logic [fits_pkg::TUSER_W-1:0]        m_tuser,  // dim_number, invalid
    output logic                                m_tlast
);

    logic [fits_pkg::NUM_DIMS_W-1:0] num_dims_reg;
    fits_pkg::sizes_t                dim_size_reg;
    logic [fits_pkg::DNUM_W-1:0]     n_last;
    fits_pkg::cmd_t                  cmd;
    fits_pkg::status_t               st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg <= fits_pkg::NUM_DIMS_W'(1);
            for (int k = 0; k < fits_pkg::MAX_DIMS; k++) begin
                dim_size_reg[k] <= fits_pkg::DIM_WIDTH'(1);
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == fits_pkg::REG_NUM_DIMS) begin
                num_dims_reg <= cfg_data[fits_pkg::NUM_DIMS_W-1:0];
            end
            for (int k = 0; k < fits_pkg::MAX_DIMS; k++) begin
                if (cfg_index == fits_pkg::CFG_IDX_W'(int'(fits_pkg::REG_DIM_SIZE_0) + k)) begin
                    dim_size_reg[k] <= cfg_data[fits_pkg::DIM_WIDTH-1:0];
                end
            end
        end
    end

    // zero dimensions act as one, too many as the maximum
    always_comb begin
        if (num_dims_reg == '0) begin
            n_last = '0;
        end else if (int'(num_dims_reg) > fits_pkg::MAX_DIMS) begin
            n_last = fits_pkg::DNUM_W'(fits_pkg::MAX_DIMS - 1);
        end else begin
            n_last = fits_pkg::DNUM_W'(num_dims_reg - 1'b1);
        end
    end

    fits_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .n_last   (n_last),
        .st       (st),
        .cmd      (cmd)
    );

    fits_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .flat_index (s_tdata),
        .n_last     (n_last),
        .dim_size   (dim_size_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== design/fits_checker.sv =====
// port-level checker for flat_index_to_subscripts, bound to the top level
module fits_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fits_pkg::DIM_WIDTH-1:0]  m_tdata,
    input logic [fits_pkg::TUSER_W-1:0]    m_tuser,
    input logic                            m_tlast
);

    // a stalled word stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // divider is busy right after an index is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new index right after accept");

    // invalid words carry coordinate zero
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[fits_pkg::DNUM_W] |-> m_tdata == '0)
        else $error("invalid word with nonzero coordinate");

endmodule

bind flat_index_to_subscripts fits_checker u_fits_checker (.*);

// ===== tb/sv/flat_index_to_subscripts_tb.sv =====
// self-checking testbench for flat_index_to_subscripts: predicts every subscript word
`timescale 1ns / 100ps

module flat_index_to_subscripts_tb;

    localparam logic [fits_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [48:0] SAT_CAP   = 49'h1_0000_0000_0000;
    localparam logic [48:0] POS_LIMIT = 49'h0_8000_0000_0000;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES = 50;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 15;

    typedef struct {
        logic [fits_pkg::DIM_WIDTH-1:0] coordinate;
        logic [fits_pkg::DNUM_W-1:0]    dim_number;
        logic                           invalid;
        logic                           last;
    } subscript_t;

    class subscript_checker;
        logic [fits_pkg::NUM_DIMS_W-1:0] num_dims;
        logic [fits_pkg::DIM_WIDTH-1:0]  dim_size [fits_pkg::MAX_DIMS];
        logic [48:0]                     stride [fits_pkg::MAX_DIMS];
        logic [48:0]                     total;
        subscript_t                      subscripts_due [$];
        int                              errors;

        function new();
            num_dims = 1;
            foreach (dim_size[k]) dim_size[k] = 1;
            errors = 0;
            rebuild_strides();
        endfunction

        function int dims_used();
            if (num_dims == 0) return 1;
            if (num_dims > fits_pkg::MAX_DIMS) return fits_pkg::MAX_DIMS;
            return int'(num_dims);
        endfunction

        function logic [48:0] sat_mul(logic [48:0] a, logic [fits_pkg::DIM_WIDTH-1:0] b);
            logic [64:0] p;
            if (a == 0 || b == 0) return 0;
            p = a * b;
            return (p > SAT_CAP) ? SAT_CAP : p[48:0];
        endfunction

        function void rebuild_strides();
            int n;
            n = dims_used();
            foreach (stride[j]) stride[j] = 1;
            for (int j = n - 1; j > 0; j--) stride[j-1] = sat_mul(stride[j], dim_size[j]);
            total = sat_mul(stride[0], dim_size[0]);
        endfunction

        function void write_reg(logic [fits_pkg::CFG_IDX_W-1:0] idx,
                                logic [fits_pkg::CFG_DATA_W-1:0] val);
            if (idx == fits_pkg::REG_NUM_DIMS) begin
                num_dims = val[fits_pkg::NUM_DIMS_W-1:0];
            end else if (idx >= fits_pkg::REG_DIM_SIZE_0 &&
                         idx < fits_pkg::REG_DIM_SIZE_0 + fits_pkg::MAX_DIMS) begin
                dim_size[idx - fits_pkg::REG_DIM_SIZE_0] = val;
            end else begin
                return;
            end
            rebuild_strides();
        endfunction

        function void take_index(logic [fits_pkg::INDEX_WIDTH-1:0] flat);
            int n;
            logic bad;
            logic [48:0] rest;
            logic [48:0] q;
            subscript_t w;
            n = dims_used();
            bad = flat[fits_pkg::INDEX_WIDTH-1] || ({1'b0, flat} >= total);
            rest = {1'b0, flat};
            for (int j = 0; j < n; j++) begin
                w.coordinate = '0;
                if (!bad && stride[j] != 0) begin
                    q = rest / stride[j];
                    rest = rest % stride[j];
                    w.coordinate = q[fits_pkg::DIM_WIDTH-1:0];
                end
                w.dim_number = j[fits_pkg::DNUM_W-1:0];
                w.invalid = bad;
                w.last = (j == n - 1);
                subscripts_due.push_back(w);
            end
        endfunction

        function int pending();
            return subscripts_due.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_subscript(logic [fits_pkg::DIM_WIDTH-1:0] coord,
                             logic [fits_pkg::TUSER_W-1:0] user, logic last);
            subscript_t w;
            if (subscripts_due.size() == 0) begin
                report($sformatf("unexpected word coord %0d tuser %h", coord, user));
                return;
            end
            w = subscripts_due.pop_front();
            if (coord !== w.coordinate)
                report($sformatf("dim %0d coordinate %0d, want %0d",
                                 w.dim_number, coord, w.coordinate));
            if (user[fits_pkg::DNUM_W-1:0] !== w.dim_number)
                report($sformatf("dim_number %0d, want %0d",
                                 user[fits_pkg::DNUM_W-1:0], w.dim_number));
            if (user[fits_pkg::DNUM_W] !== w.invalid)
                report($sformatf("dim %0d invalid %b, want %b",
                                 w.dim_number, user[fits_pkg::DNUM_W], w.invalid));
            if (last !== w.last)
                report($sformatf("dim %0d tlast %b, want %b", w.dim_number, last, w.last));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [fits_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fits_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [fits_pkg::INDEX_WIDTH-1:0] s_tdata = '0;   // flat_index
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [fits_pkg::DIM_WIDTH-1:0] m_tdata;          // coordinate
    logic [fits_pkg::TUSER_W-1:0] m_tuser;            // dim_number, invalid
    logic m_tlast;

    logic stall_on = 1'b0;
    int ready_run = 0;
    int idle_cycles = 0;

    subscript_checker sb = new();

    flat_index_to_subscripts dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn || !stall_on) begin
            m_tready <= 1'b1;
            ready_run <= 0;
        end else if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
            ready_run <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_index(s_tdata);
            if (m_tvalid && m_tready) sb.check_subscript(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("flat_index_to_subscripts_tb: done, errors");
            $finish;
        end
    end

    task automatic send_index(input logic [fits_pkg::INDEX_WIDTH-1:0] v);
        int gap;
        gap = stall_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic apply_config(input logic [fits_pkg::CFG_DATA_W-1:0] nd,
                                input fits_pkg::sizes_t sz,
                                input logic poke_unused);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (int k = 0; k <= fits_pkg::MAX_DIMS; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= (k == 0) ? fits_pkg::REG_NUM_DIMS :
                         fits_pkg::REG_DIM_SIZE_0 + fits_pkg::CFG_IDX_W'(k - 1);
            cfg_data <= (k == 0) ? nd : sz[k-1];
            @(posedge aclk);
            sb.write_reg(cfg_index, cfg_data);
        end
        if (poke_unused) begin
            cfg_index <= REG_UNUSED;
            cfg_data <= fits_pkg::CFG_DATA_W'($urandom);
            @(posedge aclk);
            sb.write_reg(cfg_index, cfg_data);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [fits_pkg::INDEX_WIDTH-1:0] random_word();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [fits_pkg::INDEX_WIDTH-1:0] pick_index();
        logic [48:0] lim;
        logic [63:0] r;
        logic [fits_pkg::INDEX_WIDTH-1:0] w;
        int sel;
        sel = $urandom_range(0, 19);
        lim = (sb.total > POS_LIMIT) ? POS_LIMIT : sb.total;
        r = {$urandom, $urandom};
        w = random_word();
        if (sel < 13) begin
            if (lim == 0) return w;
            return fits_pkg::INDEX_WIDTH'(r % lim);
        end
        if (sel == 13) return fits_pkg::INDEX_WIDTH'(sb.total - 1);
        if (sel == 14) return fits_pkg::INDEX_WIDTH'(lim);
        if (sel < 17) return {1'b1, w[fits_pkg::INDEX_WIDTH-2:0]};
        return w;
    endfunction

    function automatic logic [fits_pkg::DIM_WIDTH-1:0] pick_size();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 12) return fits_pkg::DIM_WIDTH'($urandom_range(1, 12));
        if (kind < 15) return fits_pkg::DIM_WIDTH'($urandom_range(1, 300));
        if (kind == 15) return '0;
        if (kind == 16) return '1;
        return fits_pkg::DIM_WIDTH'($urandom);
    endfunction

    initial begin
        fits_pkg::sizes_t sz;
        logic [fits_pkg::CFG_DATA_W-1:0] nd;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset sizes: one dimension of size one
        send_index(48'h0);
        send_index(48'h1);
        send_index(48'h8000_0000_0000);

        sz = '{default: 16'd1};
        sz[0] = 16'd4;
        sz[1] = 16'd5;
        sz[2] = 16'd6;
        apply_config(16'd3, sz, 1'b0);
        send_index(48'd0);
        send_index(48'd119);
        send_index(48'd120);
        send_index(48'd57);
        send_index(48'h7FFF_FFFF_FFFF);
        send_index(48'hFFFF_FFFF_FFFF);

        // zero dimensions count as one
        stall_on <= 1'b1;
        sz = '{default: 16'd1};
        sz[0] = 16'hFFFF;
        apply_config(16'hFFF8, sz, 1'b0);
        send_index(48'd65534);
        send_index(48'd65535);
        send_index(48'd1000);

        // too many dimensions, saturated strides
        sz = '{default: 16'hFFFF};
        apply_config(16'd7, sz, 1'b1);
        send_index(48'h7FFF_FFFF_FFFF);
        send_index(48'h0);
        send_index(48'h1234_5678_9ABC);

        // a zero size makes everything invalid
        sz[0] = 16'd2;
        sz[1] = 16'd3;
        sz[2] = 16'd0;
        sz[3] = 16'd5;
        sz[4] = 16'd7;
        sz[5] = 16'd9;
        apply_config(16'd6, sz, 1'b0);
        send_index(48'd0);
        send_index(48'd5);

        sz = '{default: 16'd1};
        apply_config(16'd6, sz, 1'b0);
        send_index(48'd0);
        send_index(48'd1);

        sz = '{default: 16'd1};
        sz[0] = 16'hFFFF;
        sz[1] = 16'hFFFF;
        apply_config(16'd2, sz, 1'b0);
        send_index(48'hFFFE_0000);
        send_index(48'hFFFE_0001);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            stall_on <= (p != 2) && ($urandom_range(0, 4) != 0);
            nd = fits_pkg::CFG_DATA_W'($urandom);
            if ($urandom_range(0, 1) == 0)
                nd[fits_pkg::NUM_DIMS_W-1:0] = fits_pkg::NUM_DIMS_W'($urandom_range(1, 6));
            for (int k = 0; k < fits_pkg::MAX_DIMS; k++) sz[k] = pick_size();
            apply_config(nd, sz, $urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(0, 24) == 0) drain();
                send_index(pick_index());
            end
        end

        drain();
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) sb.report($sformatf("%0d words never came", sb.pending()));
        if (sb.errors == 0) begin
            $display("flat_index_to_subscripts_tb: done, clean");
        end else begin
            $display("flat_index_to_subscripts_tb: done, errors");
        end
        $finish;
    end

endmodule
